// File: rtl/ged_pkg.sv
// Shared types, register indexes and the code table for the encoder step decoder.
`timescale 1ns / 1ps
`default_nettype none

package ged_pkg;

  localparam int unsigned CODE_W  = 3;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned IDLE_W  = 16;
  localparam int unsigned INDEX_W = 2;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [IDLE_W-1:0]  idle_t;
  typedef logic [INDEX_W-1:0] index_t;

  localparam index_t REG_JITTER_LIMIT = 2'd0;
  localparam index_t REG_IDLE_RELOAD  = 2'd1;

  localparam limit_t JITTER_LIMIT_RESET = 4'd7;
  localparam idle_t  IDLE_RELOAD_RESET  = 16'd255;

  typedef struct packed {
    logic  step_forward;
    code_t line_code;
  } result_t;

  // Successor of each code on the forward cycle 1-3-2-6-4-5; zero means none.
  function automatic code_t fwd_next(input code_t c);
    code_t n;
    begin
      unique case (c)
        3'd1:    n = 3'd3;
        3'd2:    n = 3'd6;
        3'd3:    n = 3'd2;
        3'd4:    n = 3'd5;
        3'd5:    n = 3'd1;
        3'd6:    n = 3'd4;
        default: n = 3'd0;
      endcase
      return n;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/ged_in_reg.sv
// Input register that holds one sample word until the step unit takes it.
`timescale 1ns / 1ps
`default_nettype none

module ged_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ged_pkg::code_t line_sample,
  input  wire logic          take,
  output logic               held,
  output ged_pkg::code_t     sample
);
  import ged_pkg::*;

  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= line_sample;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ged_step_unit.sv
// Configuration registers, decoder state and the per-sample step logic.
`timescale 1ns / 1ps
`default_nettype none

module ged_step_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire ged_pkg::index_t cfg_index,
  input  wire ged_pkg::idle_t  cfg_data,
  input  wire logic            fire,
  input  wire ged_pkg::code_t  sample,
  output logic                 emit,
  output ged_pkg::result_t     result
);
  import ged_pkg::*;

  limit_t jitter_limit;
  idle_t  idle_reload;
  code_t  previous_code;
  limit_t hysteresis_count;
  idle_t  idle_countdown;

  code_t  previous_code_next;
  limit_t hysteresis_count_next;
  idle_t  idle_countdown_next;

  limit_t hyst_timed;
  logic   changed;
  logic   dir_fwd;
  logic   dir_rev;
  code_t  succ_prev;
  code_t  succ_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      jitter_limit <= JITTER_LIMIT_RESET;
      idle_reload  <= IDLE_RELOAD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_JITTER_LIMIT: jitter_limit <= cfg_data[LIMIT_W-1:0];
        REG_IDLE_RELOAD:  idle_reload  <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_comb begin
    succ_prev = fwd_next(previous_code);
    succ_code = fwd_next(sample);
    changed   = sample != previous_code;
    dir_fwd   = (succ_prev != 3'd0) && (succ_prev == sample);
    dir_rev   = (succ_code != 3'd0) && (succ_code == previous_code);

    // The idle timer runs first; reaching zero re-centres the counter.
    idle_countdown_next = idle_countdown;
    hyst_timed          = hysteresis_count;
    if (idle_countdown != '0) begin
      idle_countdown_next = idle_countdown - idle_t'(1);
      if (idle_countdown == idle_t'(1)) begin
        hyst_timed = jitter_limit >> 1;
      end
    end

    hysteresis_count_next = hyst_timed;
    previous_code_next    = previous_code;
    emit                  = 1'b0;
    result.step_forward   = dir_fwd;
    result.line_code      = sample;

    if (changed) begin
      idle_countdown_next = idle_reload;
      previous_code_next  = sample;
      if (dir_fwd) begin
        if (hyst_timed >= jitter_limit) begin
          emit = 1'b1;
        end else begin
          hysteresis_count_next = hyst_timed + limit_t'(1);
        end
      end else if (dir_rev) begin
        if (hyst_timed == '0) begin
          emit = 1'b1;
        end else begin
          hysteresis_count_next = hyst_timed - limit_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_code    <= '0;
      hysteresis_count <= '0;
      idle_countdown   <= '0;
    end else if (fire) begin
      previous_code    <= previous_code_next;
      hysteresis_count <= hysteresis_count_next;
      idle_countdown   <= idle_countdown_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ged_out_reg.sv
// Result register that holds one step word until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module ged_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire ged_pkg::result_t result,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  step_forward,
  output ged_pkg::code_t        line_code
);
  import ged_pkg::*;

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      step_forward <= result.step_forward;
      line_code    <= result.line_code;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gray_encoder_step_decoder_top.sv
// Top level of the three-line Gray-code encoder step decoder.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    line_sample
//   out       source     out_valid / out_ready  step_forward, line_code
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample word is taken into the input register, then processed into the result
// register once that has room; a step word is loaded only when the sample makes a step.
// One sample word is accepted per cycle while the result register does not stall; the state update is a single pass.
// Reset clears the state, the handshakes, and loads the register defaults.
// A full result register that is not taken stalls the input register.
`timescale 1ns / 1ps
`default_nettype none

module gray_encoder_step_decoder_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ged_pkg::code_t  line_sample,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 step_forward,
  output ged_pkg::code_t       line_code,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire ged_pkg::index_t cfg_index,
  input  wire ged_pkg::idle_t  cfg_data
);
  import ged_pkg::*;

  logic    held;
  logic    room;
  logic    fire;
  logic    emit;
  code_t   sample;
  result_t result;

  assign cfg_ready = 1'b1;
  assign fire      = held && room;

  ged_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .line_sample (line_sample),
    .take        (fire),
    .held        (held),
    .sample      (sample)
  );

  ged_step_unit u_step_unit (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .sample    (sample),
    .emit      (emit),
    .result    (result)
  );

  ged_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && emit),
    .result       (result),
    .room         (room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .step_forward (step_forward),
    .line_code    (line_code)
  );

endmodule

`default_nettype wire

// File: rtl/ged_checker.sv
// Port-level checks for the encoder step decoder and their binding to the top.
`timescale 1ns / 1ps
`default_nettype none

module ged_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire ged_pkg::code_t line_sample,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire logic           step_forward,
  input wire ged_pkg::code_t line_code
);
  import ged_pkg::*;

  // A stalled step word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(step_forward) && $stable(line_code))
    else $error("stalled step word changed");

  // Reset leaves no step word pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("step word present after reset");

  // Codes zero and seven lie on neither cycle, so they never form a step.
  a_code_on_cycle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (line_code != 3'd0) && (line_code != 3'd7))
    else $error("step word carries a code outside the cycle");

  // A new step word into an empty result register comes from a sample word that passed
  // straight through the input register without a stall, and carries that sample.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) && (line_code == $past(line_sample, 2)))
    else $error("step word without matching sample word");

endmodule

bind gray_encoder_step_decoder_top ged_checker u_ged_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .line_sample  (line_sample),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .step_forward (step_forward),
  .line_code    (line_code)
);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the three-line Gray-code encoder step decoder.
`timescale 1ns / 1ps

module tb_top;
  import ged_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_ITEMS = 95;
  localparam index_t REG_UNUSED = 2'd3;

  localparam code_t NEXT_ON_CYCLE [8] = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};
  localparam code_t PREV_ON_CYCLE [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};

  typedef enum logic [1:0] {MOVE_BACK, MOVE_FWD, MOVE_NONE} move_t;

  class step_predictor;
    limit_t jitter_limit;
    idle_t idle_reload;
    code_t last_code;
    limit_t hyst_count;
    idle_t countdown;
    result_t steps_due[$];
    int unsigned errors;

    function new();
      jitter_limit = JITTER_LIMIT_RESET;
      idle_reload = IDLE_RELOAD_RESET;
      last_code = '0;
      hyst_count = '0;
      countdown = '0;
      errors = 0;
    endfunction

    function void write_reg(index_t idx, idle_t data);
      case (idx)
        REG_JITTER_LIMIT: jitter_limit = data[LIMIT_W-1:0];
        REG_IDLE_RELOAD: idle_reload = data;
        default: ;
      endcase
    endfunction

    function move_t classify(code_t from, code_t to);
      if (to != 0 && NEXT_ON_CYCLE[from] == to) return MOVE_FWD;
      if (to != 0 && PREV_ON_CYCLE[from] == to) return MOVE_BACK;
      return MOVE_NONE;
    endfunction

    function void note_sample(code_t c);
      move_t mv;
      result_t r;
      if (countdown != 0) begin
        countdown = countdown - 1'b1;
        if (countdown == 0) hyst_count = jitter_limit >> 1;
      end
      if (c == last_code) return;
      mv = classify(last_code, c);
      countdown = idle_reload;
      r.line_code = c;
      case (mv)
        MOVE_FWD: begin
          if (hyst_count >= jitter_limit) begin
            r.step_forward = 1'b1;
            steps_due.push_back(r);
          end else begin
            hyst_count = hyst_count + 1'b1;
          end
        end
        MOVE_BACK: begin
          if (hyst_count == 0) begin
            r.step_forward = 1'b0;
            steps_due.push_back(r);
          end else begin
            hyst_count = hyst_count - 1'b1;
          end
        end
        default: ;
      endcase
      last_code = c;
    endfunction

    function void check_step(logic fwd, code_t c);
      result_t exp_step;
      if (steps_due.size() == 0) begin
        $error("unexpected step word: step_forward %0d, line_code %0d", fwd, c);
        errors++;
        return;
      end
      exp_step = steps_due.pop_front();
      if (fwd !== exp_step.step_forward) begin
        $error("step_forward mismatch: expected %0d, actual %0d", exp_step.step_forward, fwd);
        errors++;
      end
      if (c !== exp_step.line_code) begin
        $error("line_code mismatch: expected %0d, actual %0d", exp_step.line_code, c);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  code_t line_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic step_forward;
  code_t line_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  index_t cfg_index = '0;
  idle_t cfg_data = '0;

  step_predictor sb = new();
  int unsigned send_gap = 17;
  int unsigned take_gap = 58;
  code_t cur_code = '0;

  gray_encoder_step_decoder_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .line_sample(line_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .step_forward(step_forward),
    .line_code(line_code),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_step(step_forward, line_code);
    out_ready <= ($urandom_range(99) >= take_gap);
  end

  task automatic send_sample(input code_t c);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    line_sample <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(c);
    cur_code = c;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.steps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input index_t idx, input idle_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input idle_t limit_data, input idle_t reload);
    wait_drained();
    write_reg(REG_JITTER_LIMIT, limit_data);
    write_reg(REG_IDLE_RELOAD, reload);
    cfg_valid <= 1'b0;
  endtask

  task automatic forward_run(input int unsigned n);
    repeat (n) begin
      if (NEXT_ON_CYCLE[cur_code] == 0) send_sample(3'd1);
      else send_sample(NEXT_ON_CYCLE[cur_code]);
    end
  endtask

  task automatic random_walk(input int unsigned count);
    int unsigned done_cnt;
    int unsigned len;
    int unsigned pick;
    logic fwd;
    code_t c;
    done_cnt = 0;
    while (done_cnt < count) begin
      pick = $urandom_range(99);
      len = $urandom_range(1, 12);
      fwd = 1'($urandom_range(1));
      repeat (len) begin
        c = cur_code;
        if (pick < 70) begin
          if (NEXT_ON_CYCLE[c] == 0) c = code_t'($urandom_range(1, 6));
          else c = fwd ? NEXT_ON_CYCLE[c] : PREV_ON_CYCLE[c];
        end else if (pick >= 85) begin
          c = code_t'($urandom_range(7));
        end
        send_sample(c);
        done_cnt++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // With the reset registers: unchanged, off-cycle, reverse at zero, then forward to the limit.
    send_sample(3'd0);
    send_sample(3'd7);
    send_sample(3'd1);
    send_sample(3'd5);
    send_sample(3'd4);
    send_sample(3'd6);
    forward_run(9);
    send_sample(3'd2);
    send_sample(3'd2);
    send_sample(3'd0);
    random_walk(PHASE_ITEMS);

    set_config(16'd0, 16'd0);
    random_walk(PHASE_ITEMS);

    set_config(16'd15, 16'hFFFF);
    random_walk(PHASE_ITEMS);
    forward_run(16);

    send_gap = 58;
    take_gap = 17;
    // Lowering the limit leaves the counter above it.
    set_config(16'd3, 16'd1);
    forward_run(4);
    random_walk(PHASE_ITEMS);

    wait_drained();
    write_reg(REG_UNUSED, 16'hA5A5);
    write_reg(REG_JITTER_LIMIT, 16'hFFFC);
    write_reg(REG_IDLE_RELOAD, 16'd5);
    cfg_valid <= 1'b0;
    random_walk(PHASE_ITEMS);

    set_config(16'd1, 16'd3);
    random_walk(PHASE_ITEMS);

    send_gap = 0;
    take_gap = 0;
    set_config(16'd5, 16'd10);
    random_walk(PHASE_ITEMS);

    set_config(16'd15, 16'd2);
    random_walk(PHASE_ITEMS);

    wait_drained();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
